// ===== design/sbts_pkg.sv =====
`timescale 1ns / 1ps
package sbts_pkg;
	localparam int FRAC_BITS_DEF = 20;
	localparam logic [31:0] DT_RST = 32'd4294967;
	localparam logic [31:0] DRAG_RST = 32'd171798692;
	localparam logic [31:0] MAG_RST = 32'd1760937;
	localparam logic [31:0] SPIN_RST = 32'd219613233;
	localparam logic [31:0] HEIGHT_RST = 32'd2097152;

	localparam logic [2:0] REG_DT = 3'd0;
	localparam logic [2:0] REG_DRAG = 3'd1;
	localparam logic [2:0] REG_MAG = 3'd2;
	localparam logic [2:0] REG_SPIN = 3'd3;
	localparam logic [2:0] REG_SENSE = 3'd4;
	localparam logic [2:0] REG_HEIGHT = 3'd5;

	typedef enum logic [4:0] {
		OP_LAUNCH,
		OP_SQX, OP_SQY, OP_SQZ,
		OP_SQRT_START,
		OP_POSX, OP_POSY, OP_POSZ,
		OP_VY,
		OP_KD, OP_A, OP_DTERM,
		OP_KM, OP_MS, OP_CZ, OP_NVX, OP_CX, OP_NVZ,
		OP_DIV_START,
		OP_LANDX, OP_LANDZ, OP_FINISH,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic sqrt_busy;
		logic div_busy;
		logic ready_tick;
		logic need_land;
	} stat_t;
endpackage

// ===== design/sbts_ctrl.sv =====
`timescale 1ns / 1ps
module sbts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            action,
	input  logic            out_stall,
	input  sbts_pkg::stat_t stat,
	output logic            in_stall,
	output logic            out_valid,
	output sbts_pkg::cmd_t  cmd
);
	typedef enum logic [2:0] {S_IDLE, S_RUN, S_SQRT, S_DIV, S_OUT} state_t;
	state_t state_q;
	sbts_pkg::op_t op_q;
	logic out_valid_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.op = sbts_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					cmd.op = action ? sbts_pkg::OP_SQX : sbts_pkg::OP_LAUNCH;
			end
			S_RUN: cmd.op = op_q;
			default: cmd.op = sbts_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= sbts_pkg::OP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (!action || !stat.ready_tick) begin
							state_q <= S_OUT;
							out_valid_q <= 1'b1;
						end else begin
							state_q <= S_RUN;
							op_q <= sbts_pkg::OP_SQY;
						end
					end
				end
				S_RUN: begin
					case (op_q)
						sbts_pkg::OP_SQRT_START: state_q <= S_SQRT;
						sbts_pkg::OP_NVZ: begin
							if (stat.need_land) op_q <= sbts_pkg::OP_DIV_START;
							else op_q <= sbts_pkg::OP_FINISH;
						end
						sbts_pkg::OP_DIV_START: state_q <= S_DIV;
						sbts_pkg::OP_FINISH: begin
							state_q <= S_OUT;
							out_valid_q <= 1'b1;
						end
						default: op_q <= sbts_pkg::op_t'(op_q + 5'd1);
					endcase
				end
				S_SQRT: begin
					if (!stat.sqrt_busy) begin
						state_q <= S_RUN;
						op_q <= sbts_pkg::OP_POSX;
					end
				end
				S_DIV: begin
					if (!stat.div_busy) begin
						state_q <= S_RUN;
						op_q <= sbts_pkg::OP_LANDX;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/sbts_dp.sv =====
`timescale 1ns / 1ps
module sbts_dp #(
	parameter int FRAC_BITS = sbts_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sbts_pkg::cmd_t     cmd,
	output sbts_pkg::stat_t    stat,
	input  logic               cfg_valid,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic signed [31:0] launch_vx,
	input  logic signed [31:0] launch_vy,
	input  logic signed [31:0] launch_vz,
	output logic signed [31:0] pos_x_out,
	output logic signed [31:0] pos_y_out,
	output logic signed [31:0] pos_z_out,
	output logic               landed,
	output logic signed [31:0] landing_x,
	output logic signed [31:0] landing_z
);
	localparam logic signed [33:0] G_FIX_W =
		34'(((64'sd98 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
	localparam logic signed [31:0] G_FIX = (G_FIX_W > 34'sd2147483647) ?
		32'sh7fffffff : G_FIX_W[31:0];

	logic [31:0] dt_q, drag_q, mag_q, spin_q, height_q;
	logic sense_q;
	logic signed [31:0] px_q, py_q, pz_q, vx_q, vy_q, vz_q;
	logic signed [31:0] prx_q, pry_q, prz_q, lx_q, lz_q;
	logic fly_q, land_q;
	logic signed [31:0] vxo_q, vzo_q, dterm_q, cz_q, nvx_q;
	logic [31:0] kd_q, a_q, km_q, ms_q, speed_q;
	logic [63:0] sq_q, t_q;

	// shared signed x unsigned multiply with rounded shift
	logic signed [31:0] ma;
	logic [31:0] mb;
	logic sh32;
	logic [31:0] mag_a;
	logic [63:0] prod, rnd;
	logic [63:0] shv;
	logic signed [64:0] mres;
	logic signed [31:0] msat;

	always_comb begin
		ma = '0; mb = '0; sh32 = 1'b1;
		case (cmd.op)
			sbts_pkg::OP_SQX: begin
				ma = vx_q; mb = vx_q[31] ? 32'(-vx_q) : 32'(vx_q);
			end
			sbts_pkg::OP_SQY: begin
				ma = vy_q; mb = vy_q[31] ? 32'(-vy_q) : 32'(vy_q);
			end
			sbts_pkg::OP_SQZ: begin
				ma = vz_q; mb = vz_q[31] ? 32'(-vz_q) : 32'(vz_q);
			end
			sbts_pkg::OP_POSX: begin ma = vxo_q; mb = dt_q; end
			sbts_pkg::OP_POSY: begin ma = vy_q; mb = dt_q; end
			sbts_pkg::OP_POSZ: begin ma = vzo_q; mb = dt_q; end
			sbts_pkg::OP_VY: begin ma = G_FIX; mb = dt_q; end
			sbts_pkg::OP_KD: begin ma = $signed(drag_q); mb = dt_q; end
			sbts_pkg::OP_A: begin ma = $signed(speed_q); mb = kd_q; end
			sbts_pkg::OP_DTERM: begin ma = vxo_q; mb = a_q; sh32 = 1'b0; end
			sbts_pkg::OP_KM: begin ma = $signed(mag_q); mb = dt_q; end
			sbts_pkg::OP_MS: begin ma = $signed(spin_q); mb = km_q; end
			sbts_pkg::OP_CZ: begin ma = vzo_q; mb = ms_q; sh32 = 1'b0; end
			sbts_pkg::OP_CX: begin ma = nvx_q; mb = ms_q; sh32 = 1'b0; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// unsigned operands (drag, speed, ...) are treated as magnitudes
	logic uns;
	assign uns = (cmd.op == sbts_pkg::OP_KD) || (cmd.op == sbts_pkg::OP_A)
		|| (cmd.op == sbts_pkg::OP_KM) || (cmd.op == sbts_pkg::OP_MS);
	logic neg;
	assign neg = !uns && ma[31];
	assign mag_a = neg ? 32'(-ma) : ma;
	assign prod = 64'(mag_a) * 64'(mb);
	assign rnd = sh32 ? prod + 64'h8000_0000 : prod + (64'd1 << (FRAC_BITS - 1));
	assign shv = sh32 ? {32'd0, rnd[63:32]} : (rnd >> FRAC_BITS);
	assign mres = neg ? -$signed({1'b0, shv}) : $signed({1'b0, shv});
	assign msat = (mres > 65'sd2147483647) ? 32'sh7fffffff :
		(mres < -65'sd2147483648) ? 32'sh80000000 : mres[31:0];

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] x,
		input logic signed [31:0] y, input logic sub);
		logic signed [32:0] s;
		begin
			s = sub ? 33'(x) - 33'(y) : 33'(x) + 33'(y);
			if (s > 33'sd2147483647) sat_add = 32'sh7fffffff;
			else if (s < -33'sd2147483648) sat_add = 32'sh80000000;
			else sat_add = s[31:0];
		end
	endfunction

	// square magnitude is the product itself, not shifted
	// isqrt: one result bit per cycle
	logic sq_busy_q;
	logic [63:0] rem_q;
	logic [31:0] root_q;
	logic [5:0] sq_cnt_q;
	logic [65:0] trial;
	logic [65:0] rem_sh;
	assign rem_sh = {rem_q, sq_q[63:62]};
	assign trial = rem_sh - {32'd0, root_q, 2'b01};

	// divider for landing fraction, restoring, one bit per cycle
	logic div_busy_q;
	logic [6:0] dv_cnt_q;
	logic [32:0] dv_rem_q, dv_den_q;
	logic [63:0] dv_num_q;
	logic [33:0] dv_try;
	assign dv_try = {dv_rem_q, dv_num_q[63]} - {1'b0, dv_den_q};

	logic signed [32:0] dy;
	assign dy = 33'(pry_q) - 33'(py_q);

	// interpolation multiply of a 33-bit difference by t
	logic signed [32:0] id;
	logic [32:0] id_mag;
	logic [65:0] iprod;
	logic [33:0] ish;
	logic signed [34:0] ires;
	logic signed [31:0] isat;
	assign id = (cmd.op == sbts_pkg::OP_LANDX) ? 33'(px_q) - 33'(prx_q)
		: 33'(pz_q) - 33'(prz_q);
	assign id_mag = id[32] ? 33'(-id) : id;
	assign iprod = 66'(id_mag) * 66'(t_q[31:0]);
	assign ish = 34'((iprod + 66'h8000_0000) >> 32);
	assign ires = (cmd.op == sbts_pkg::OP_LANDX ? 35'(prx_q) : 35'(prz_q)) +
		(id[32] ? -$signed({1'b0, ish}) : $signed({1'b0, ish}));
	assign isat = (ires > 35'sd2147483647) ? 32'sh7fffffff :
		(ires < -35'sd2147483648) ? 32'sh80000000 : ires[31:0];

	assign stat.sqrt_busy = sq_busy_q;
	assign stat.div_busy = div_busy_q;
	assign stat.ready_tick = fly_q && !land_q;
	assign stat.need_land = py_q[31];

	assign pos_x_out = px_q;
	assign pos_y_out = py_q;
	assign pos_z_out = pz_q;
	assign landed = land_q;
	assign landing_x = land_q ? lx_q : '0;
	assign landing_z = land_q ? lz_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= sbts_pkg::DT_RST; drag_q <= sbts_pkg::DRAG_RST;
			mag_q <= sbts_pkg::MAG_RST; spin_q <= sbts_pkg::SPIN_RST;
			sense_q <= 1'b0; height_q <= sbts_pkg::HEIGHT_RST;
			px_q <= '0; py_q <= '0; pz_q <= '0;
			vx_q <= '0; vy_q <= '0; vz_q <= '0;
			prx_q <= '0; pry_q <= '0; prz_q <= '0;
			lx_q <= '0; lz_q <= '0;
			fly_q <= 1'b0; land_q <= 1'b0;
			sq_busy_q <= 1'b0; div_busy_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					sbts_pkg::REG_DT: dt_q <= cfg_data;
					sbts_pkg::REG_DRAG: drag_q <= cfg_data;
					sbts_pkg::REG_MAG: mag_q <= cfg_data;
					sbts_pkg::REG_SPIN: spin_q <= cfg_data;
					sbts_pkg::REG_SENSE: sense_q <= cfg_data[0];
					sbts_pkg::REG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (sq_busy_q) begin
				sq_q <= {sq_q[61:0], 2'b00};
				if (!trial[65]) begin
					rem_q <= trial[63:0];
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh[63:0];
					root_q <= {root_q[30:0], 1'b0};
				end
				sq_cnt_q <= sq_cnt_q - 6'd1;
				if (sq_cnt_q == 6'd1) sq_busy_q <= 1'b0;
			end
			if (div_busy_q) begin
				dv_num_q <= {dv_num_q[62:0], 1'b0};
				if (!dv_try[33]) begin
					dv_rem_q <= dv_try[32:0];
					t_q <= {t_q[62:0], 1'b1};
				end else begin
					dv_rem_q <= {dv_rem_q[31:0], dv_num_q[63]};
					t_q <= {t_q[62:0], 1'b0};
				end
				dv_cnt_q <= dv_cnt_q - 7'd1;
				if (dv_cnt_q == 7'd1) div_busy_q <= 1'b0;
			end
			case (cmd.op)
				sbts_pkg::OP_LAUNCH: begin
					px_q <= '0; py_q <= $signed(height_q); pz_q <= '0;
					prx_q <= '0; pry_q <= $signed(height_q); prz_q <= '0;
					vx_q <= launch_vx; vy_q <= launch_vy; vz_q <= launch_vz;
					lx_q <= '0; lz_q <= '0;
					fly_q <= 1'b1; land_q <= 1'b0;
				end
				sbts_pkg::OP_SQX: begin
					sq_q <= prod; vxo_q <= vx_q; vzo_q <= vz_q;
				end
				sbts_pkg::OP_SQY, sbts_pkg::OP_SQZ: sq_q <= sq_q + prod;
				sbts_pkg::OP_SQRT_START: begin
					sq_busy_q <= 1'b1; sq_cnt_q <= 6'd32;
					rem_q <= '0; root_q <= '0;
				end
				sbts_pkg::OP_POSX: begin
					speed_q <= root_q; prx_q <= px_q; px_q <= sat_add(px_q, msat, 1'b0);
				end
				sbts_pkg::OP_POSY: begin
					pry_q <= py_q; py_q <= sat_add(py_q, msat, 1'b0);
				end
				sbts_pkg::OP_POSZ: begin
					prz_q <= pz_q; pz_q <= sat_add(pz_q, msat, 1'b0);
				end
				sbts_pkg::OP_VY: vy_q <= sat_add(vy_q, msat, 1'b1);
				sbts_pkg::OP_KD: kd_q <= shv[31:0];
				sbts_pkg::OP_A: a_q <= shv[31:0];
				sbts_pkg::OP_DTERM: dterm_q <= msat;
				sbts_pkg::OP_KM: km_q <= shv[31:0];
				sbts_pkg::OP_MS: ms_q <= shv[31:0];
				sbts_pkg::OP_CZ: cz_q <= msat;
				sbts_pkg::OP_NVX: begin
					nvx_q <= sat_add(sat_add(vxo_q, dterm_q, 1'b1), cz_q, !sense_q);
					vx_q <= sat_add(sat_add(vxo_q, dterm_q, 1'b1), cz_q, !sense_q);
				end
				sbts_pkg::OP_CX: vz_q <= sat_add(vzo_q, msat, !sense_q);
				sbts_pkg::OP_DIV_START: begin
					t_q <= '0;
					if (!pry_q[31] && pry_q != '0) begin
						div_busy_q <= 1'b1; dv_cnt_q <= 7'd64;
						dv_num_q <= {pry_q, 32'd0}; dv_rem_q <= '0;
						dv_den_q <= dy;
					end
				end
				sbts_pkg::OP_LANDX: lx_q <= isat;
				sbts_pkg::OP_LANDZ: begin
					lz_q <= isat; land_q <= 1'b1; fly_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== design/spin_ball_trajectory_step.sv =====
`timescale 1ns / 1ps
// channel   | direction | handshake          | payload
// in        | input     | in_valid/in_stall  | action, launch_vx/vy/vz
// out       | output    | out_valid/out_stall| pos_*_out, landed, landing_x/z
// cfg       | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// Launch or idle tick: the result is offered the cycle after acceptance.
// Flight tick: between acceptance and the result transfer run the bit-serial
// square root and the serial multiply steps; a landing tick adds the bit-serial
// divider, which is skipped when the previous height is not above ground. One
// item at a time; in_stall stays high until the result transfers. Reset loads
// the default registers and clears the ball, flight and busy state.
module spin_ball_trajectory_step #(
	parameter int FRAC_BITS = sbts_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic signed [31:0] launch_vx,
	input  logic signed [31:0] launch_vy,
	input  logic signed [31:0] launch_vz,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x_out,
	output logic signed [31:0] pos_y_out,
	output logic signed [31:0] pos_z_out,
	output logic               landed,
	output logic signed [31:0] landing_x,
	output logic signed [31:0] landing_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	sbts_pkg::cmd_t cmd;
	sbts_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	sbts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .action(action),
		.out_stall(out_stall), .stat(stat), .in_stall(in_stall),
		.out_valid(out_valid), .cmd(cmd)
	);

	sbts_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.launch_vx(launch_vx), .launch_vy(launch_vy), .launch_vz(launch_vz),
		.pos_x_out(pos_x_out), .pos_y_out(pos_y_out), .pos_z_out(pos_z_out),
		.landed(landed), .landing_x(landing_x), .landing_z(landing_z)
	);
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	localparam logic ACT_LAUNCH = 1'b0;
	localparam logic ACT_TICK = 1'b1;
	localparam longint GRAVITY = ((64'sd98 <<< sbts_pkg::FRAC_BITS_DEF) + 5) / 10;

	typedef struct {
		logic action;
		logic signed [31:0] vx, vy, vz;
	} throw_t;

	typedef struct {
		logic signed [31:0] px, py, pz;
		logic land;
		logic signed [31:0] lx, lz;
	} ball_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = ACT_TICK;
	logic signed [31:0] launch_vx = '0, launch_vy = '0, launch_vz = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] pos_x_out, pos_y_out, pos_z_out, landing_x, landing_z;
	logic landed;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = sbts_pkg::REG_DT;
	logic [31:0] cfg_data = '0;

	throw_t pending[$];
	ball_t flight_q[$];
	bit calm = 1'b0;
	int errors = 0;

	bit [31:0] m_dt = sbts_pkg::DT_RST, m_drag = sbts_pkg::DRAG_RST;
	bit [31:0] m_mag = sbts_pkg::MAG_RST, m_spin = sbts_pkg::SPIN_RST;
	bit m_sense = 1'b0;
	longint m_height = longint'(signed'(sbts_pkg::HEIGHT_RST));
	longint px, py, pz, vx_s, vy_s, vz_s, ox, oy, oz, lx, lz;
	bit flying = 1'b0, down = 1'b0;

	spin_ball_trajectory_step dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint scale(longint a, bit [63:0] b, int sh);
		bit [63:0] m, p;
		m = (a < 0) ? 64'd0 - a : a;
		p = (m * b + (64'd1 << (sh - 1))) >> sh;
		return (a < 0) ? -longint'(p) : longint'(p);
	endfunction

	function automatic bit [63:0] root(bit [63:0] n);
		bit [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void integrate();
		longint vx, vy, vz, kd, a, dterm, km, ms, cz, cx, nvx;
		bit [63:0] speed, t;
		vx = vx_s; vy = vy_s; vz = vz_s;
		speed = root(64'(vx * vx) + 64'(vy * vy) + 64'(vz * vz));
		ox = px; oy = py; oz = pz;
		px = clamp32(px + scale(vx, m_dt, 32));
		py = clamp32(py + scale(vy, m_dt, 32));
		pz = clamp32(pz + scale(vz, m_dt, 32));
		vy_s = clamp32(vy - clamp32(scale(clamp32(GRAVITY), m_dt, 32)));
		kd = scale(longint'(m_drag), m_dt, 32);
		a = scale(longint'(speed), kd, 32);
		dterm = clamp32(scale(vx, a, sbts_pkg::FRAC_BITS_DEF));
		km = scale(longint'(m_mag), m_dt, 32);
		ms = scale(longint'(m_spin), km, 32);
		cz = clamp32(scale(vz, ms, sbts_pkg::FRAC_BITS_DEF));
		nvx = m_sense ? clamp32(vx - dterm + cz) : clamp32(vx - dterm - cz);
		vx_s = nvx;
		cx = clamp32(scale(nvx, ms, sbts_pkg::FRAC_BITS_DEF));
		vz_s = m_sense ? clamp32(vz + cx) : clamp32(vz - cx);
		if (py < 0) begin
			t = 0;
			if (oy > 0) t = (64'(oy) << 32) / 64'(oy - py);
			lx = clamp32(ox + scale(px - ox, t, 32));
			lz = clamp32(oz + scale(pz - oz, t, 32));
			down = 1'b1;
			flying = 1'b0;
		end
	endfunction

	function automatic ball_t predict_ball(throw_t it);
		ball_t b;
		if (it.action == ACT_LAUNCH) begin
			px = 0; py = m_height; pz = 0;
			ox = 0; oy = m_height; oz = 0;
			vx_s = it.vx; vy_s = it.vy; vz_s = it.vz;
			lx = 0; lz = 0;
			flying = 1'b1;
			down = 1'b0;
		end else if (flying && !down)
			integrate();
		b.px = px[31:0]; b.py = py[31:0]; b.pz = pz[31:0];
		b.land = down;
		b.lx = down ? lx[31:0] : '0;
		b.lz = down ? lz[31:0] : '0;
		return b;
	endfunction

	always @(posedge clk) begin
		if (!arst_n)
			in_valid <= 1'b0;
		else begin
			if (in_valid && !in_stall)
				flight_q = {flight_q,
					predict_ball(throw_t'{action, launch_vx, launch_vy, launch_vz})};
			if (!in_valid || !in_stall) begin
				if (pending.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
					throw_t it;
					it = pending.pop_front();
					action <= it.action;
					launch_vx <= it.vx;
					launch_vy <= it.vy;
					launch_vz <= it.vz;
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (flight_q.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				ball_t e;
				e = flight_q.pop_front();
				if (pos_x_out !== e.px) begin
					$error("pos_x_out exp %0d got %0d", e.px, pos_x_out); errors++;
				end
				if (pos_y_out !== e.py) begin
					$error("pos_y_out exp %0d got %0d", e.py, pos_y_out); errors++;
				end
				if (pos_z_out !== e.pz) begin
					$error("pos_z_out exp %0d got %0d", e.pz, pos_z_out); errors++;
				end
				if (landed !== e.land) begin
					$error("landed exp %0d got %0d", e.land, landed); errors++;
				end
				if (landing_x !== e.lx) begin
					$error("landing_x exp %0d got %0d", e.lx, landing_x); errors++;
				end
				if (landing_z !== e.lz) begin
					$error("landing_z exp %0d got %0d", e.lz, landing_z); errors++;
				end
			end
		end
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 29);
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			sbts_pkg::REG_DT: m_dt = data;
			sbts_pkg::REG_DRAG: m_drag = data;
			sbts_pkg::REG_MAG: m_mag = data;
			sbts_pkg::REG_SPIN: m_spin = data;
			sbts_pkg::REG_SENSE: m_sense = data[0];
			sbts_pkg::REG_HEIGHT: m_height = longint'(signed'(data));
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending.size() > 0 || in_valid || flight_q.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void add_launch(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
		pending = {pending, throw_t'{ACT_LAUNCH, vx, vy, vz}};
	endfunction

	function automatic void add_ticks(int n);
		repeat (n) pending = {pending, throw_t'{ACT_TICK, $urandom, $urandom, $urandom}};
	endfunction

	function automatic logic [31:0] speed_in(int lim);
		return $urandom_range(0, 2 * (lim << 20)) - (lim << 20);
	endfunction

	function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi);
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		add_ticks(2);
		add_launch(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		add_ticks(2);
		add_launch(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		add_ticks(2);
		add_launch(speed_in(40), -(32'sd2000 <<< 20), speed_in(10));
		add_ticks(3);
		add_launch(32'd0, 32'd0, 32'd0);
		add_ticks(1);
		drain();
		write_reg(sbts_pkg::REG_HEIGHT, -(32'sd1 <<< 20));
		add_launch(speed_in(20), speed_in(20), speed_in(20));
		add_ticks(2);
		drain();
		write_reg(sbts_pkg::REG_HEIGHT, 32'd0);
		write_reg(sbts_pkg::REG_SENSE, 32'd1);
		add_launch(speed_in(20), -(32'sd1 <<< 20), speed_in(20));
		add_ticks(2);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			int made;
			case (ph)
				0: begin
					write_reg(sbts_pkg::REG_DT, 32'hFFFF_FFFF);
					write_reg(sbts_pkg::REG_DRAG, 32'hFFFF_FFFF);
					write_reg(sbts_pkg::REG_MAG, 32'hFFFF_FFFF);
					write_reg(sbts_pkg::REG_SPIN, 32'hFFFF_FFFF);
					write_reg(sbts_pkg::REG_HEIGHT, 32'h7FFF_FFFF);
				end
				1: begin
					write_reg(sbts_pkg::REG_DT, 32'd0);
					write_reg(sbts_pkg::REG_DRAG, 32'd0);
					write_reg(sbts_pkg::REG_MAG, 32'd0);
					write_reg(sbts_pkg::REG_SPIN, 32'd0);
					write_reg(sbts_pkg::REG_HEIGHT, 32'h8000_0000);
				end
				default: begin
					write_reg(sbts_pkg::REG_DT, $urandom_range(32'd429496730, 32'd42949673));
					write_reg(sbts_pkg::REG_DRAG, pick(32'd0, 32'd858993459));
					write_reg(sbts_pkg::REG_MAG, pick(32'd0, 32'd42949673));
					write_reg(sbts_pkg::REG_SPIN, pick(32'd0, 32'd1048576000));
					write_reg(sbts_pkg::REG_HEIGHT, $urandom_range(0, 32'd52428800));
				end
			endcase
			write_reg(sbts_pkg::REG_SENSE, $urandom);
			calm = (ph == 4);
			made = 0;
			while (made < 90) begin
				int n;
				if ($urandom_range(99) < 15) begin
					add_launch($urandom, $urandom, $urandom);
					n = $urandom_range(4);
				end else begin
					add_launch(speed_in(60), $urandom_range(0, 40 << 20), speed_in(15));
					n = $urandom_range(40, 5);
				end
				add_ticks(n);
				made += n + 1;
			end
			drain();
		end
		calm = 1'b0;
		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#40ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
